@@ sv/mhs_pkg.sv @@
// Shared types and constants of the modulo hash set.
package mhs_pkg;

  // Default sizes of the store
  localparam int NUM_BUCKETS_DEF = 64;
  localparam int WAYS_DEF        = 8;
  localparam int KEY_BITS_DEF    = 32;

  // Fixed field widths
  localparam int CMD_BITS    = 2;
  localparam int KEY_IN_BITS = 32;
  localparam int CFG_BITS    = 7;

  // Bucket count after reset
  localparam logic [CFG_BITS-1:0] CFG_RESET = 7'd64;

  typedef enum logic [CMD_BITS-1:0] {
    CMD_INSERT = 2'd0,
    CMD_SEARCH = 2'd1,
    CMD_CLEAR  = 2'd2
  } cmd_e;

  typedef struct packed {
    cmd_e                   command;
    logic [KEY_IN_BITS-1:0] key;
  } in_word_t;

  typedef struct packed {
    logic found;
    logic status;
  } out_word_t;

endpackage

@@ sv/modulo_hash_set_unit.sv @@
// Top level of the modulo hash set: control sequencer over fill and key RAMs.
//
//   channel   direction  handshake               word
//   in        input      in_valid_i/in_ready_o   in_word_i  (command, key)
//   out       output     out_valid_o/out_ready_i out_word_o (found, status)
//   cfg       input      cfg_we_i                cfg_data_i (bucket count)
//
// One word at a time. An insert takes its bucket index from a one-bit-per-cycle remainder
// divider, then does one fill RAM read and one write. A search reads the fill count too,
// then the key RAM slots of its bucket in order, stopping at the first match. Clear sweeps
// the fill RAM, writing zero to every bucket. After reset the same sweep runs with in_ready_o
// low; configuration writes are taken at any time. A result waits in the output register
// while the next word is taken; with out_ready_i low the next result holds the input off.
module modulo_hash_set_unit #(
  parameter int NUM_BUCKETS = mhs_pkg::NUM_BUCKETS_DEF,
  parameter int WAYS        = mhs_pkg::WAYS_DEF,
  parameter int KEY_BITS    = mhs_pkg::KEY_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  mhs_pkg::in_word_t             in_word_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output mhs_pkg::out_word_t            out_word_o,
  input  logic                          cfg_we_i,
  input  logic [mhs_pkg::CFG_BITS-1:0]  cfg_data_i
);

  import mhs_pkg::*;

  localparam int DW      = (KEY_BITS < KEY_IN_BITS) ? KEY_BITS : KEY_IN_BITS;
  localparam int BW      = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
  localparam int SLOTS   = NUM_BUCKETS * WAYS;
  localparam int AW      = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int FW      = $clog2(WAYS + 1);
  localparam int DIV_MAX = (NUM_BUCKETS > 127) ? 127 : NUM_BUCKETS;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_DIV,
    S_FILL,
    S_SRCH,
    S_RESP
  } state_e;

  state_e              state_q;
  logic [CFG_BITS-1:0] bcount_q;
  logic [BW-1:0]       clr_q;
  logic                clr_cmd_q;
  cmd_e                cmd_q;
  logic [KEY_BITS-1:0] key_q;
  logic [BW-1:0]       bkt_q;
  logic [AW-1:0]       base_q;
  logic [FW-1:0]       fill_q;
  logic [FW-1:0]       idx_q;
  out_word_t           res_q;
  out_word_t           out_q;
  logic                out_valid_q;

  logic                accept;
  logic                div_start, div_done;
  logic [CFG_BITS-1:0] divisor, rem;
  logic [BW-1:0]       bkt_div;
  logic [FW-1:0]       fill_rd, fill_now, fill_wdata;
  logic                fill_we;
  logic [BW-1:0]       fill_waddr;
  logic                key_we;
  logic [AW-1:0]       key_waddr, key_raddr;
  logic [KEY_BITS-1:0] key_rd;
  logic                hit, last;

  // bucket count register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bcount_q <= CFG_RESET;
    end else if (cfg_we_i) begin
      bcount_q <= cfg_data_i;
    end
  end

  // divisor in use: zero reads as one, clamp to the bucket count of the store
  always_comb begin
    if (bcount_q == '0) begin
      divisor = CFG_BITS'(1);
    end else if (32'(bcount_q) > NUM_BUCKETS) begin
      divisor = CFG_BITS'(DIV_MAX);
    end else begin
      divisor = bcount_q;
    end
  end

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign div_start  = accept && ((in_word_i.command == CMD_INSERT) ||
                                 (in_word_i.command == CMD_SEARCH));

  mhs_div #(
    .DIVIDEND_BITS (DW),
    .DIVISOR_BITS  (CFG_BITS)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (in_word_i.key[DW-1:0]),
    .divisor_i  (divisor),
    .done_o     (div_done),
    .rem_o      (rem)
  );

  assign bkt_div = BW'(rem);

  // fill count of the bucket, never above WAYS
  assign fill_now = (fill_rd > FW'(WAYS)) ? FW'(WAYS) : fill_rd;

  // fill RAM write: clearing sweep or insert update
  always_comb begin
    fill_we    = 1'b0;
    fill_waddr = bkt_q;
    fill_wdata = fill_now + FW'(1);
    if (state_q == S_CLEAR) begin
      fill_we    = 1'b1;
      fill_waddr = clr_q;
      fill_wdata = '0;
    end else if (state_q == S_FILL && cmd_q == CMD_INSERT && fill_now < FW'(WAYS)) begin
      fill_we = 1'b1;
    end
  end

  mhs_ram #(
    .WIDTH (FW),
    .DEPTH (NUM_BUCKETS)
  ) u_fill_ram (
    .clk_i   (clk_i),
    .we_i    (fill_we),
    .waddr_i (fill_waddr),
    .wdata_i (fill_wdata),
    .raddr_i (bkt_div),
    .rdata_o (fill_rd)
  );

  // key RAM: insert writes the next free slot, search walks the slots
  assign key_we    = (state_q == S_FILL) && (cmd_q == CMD_INSERT) && (fill_now < FW'(WAYS));
  assign key_waddr = base_q + AW'(fill_now);
  assign key_raddr = (state_q == S_SRCH) ? (base_q + AW'(idx_q) + AW'(1)) : base_q;

  mhs_ram #(
    .WIDTH (KEY_BITS),
    .DEPTH (SLOTS)
  ) u_key_ram (
    .clk_i   (clk_i),
    .we_i    (key_we),
    .waddr_i (key_waddr),
    .wdata_i (key_q),
    .raddr_i (key_raddr),
    .rdata_o (key_rd)
  );

  assign hit  = (key_rd == key_q);
  assign last = (FW'(idx_q + FW'(1)) == fill_q);

  // sequencer and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      clr_cmd_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      // a taken word leaves the output register unless a new one is loaded
      if (out_ready_i && (state_q != S_RESP)) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_CLEAR: begin
          if (clr_q == BW'(NUM_BUCKETS - 1)) begin
            clr_q   <= '0;
            state_q <= clr_cmd_q ? S_RESP : S_IDLE;
          end else begin
            clr_q <= clr_q + BW'(1);
          end
        end
        S_IDLE: begin
          if (accept) begin
            cmd_q     <= in_word_i.command;
            key_q     <= KEY_BITS'(in_word_i.key[DW-1:0]);
            res_q     <= '0;
            clr_cmd_q <= (in_word_i.command == CMD_CLEAR);
            case (in_word_i.command) inside
              CMD_INSERT, CMD_SEARCH: state_q <= S_DIV;
              CMD_CLEAR:              state_q <= S_CLEAR;
              default:                state_q <= S_RESP;
            endcase
          end
        end
        S_DIV: begin
          if (div_done) begin
            bkt_q   <= bkt_div;
            base_q  <= AW'(bkt_div) * AW'(WAYS);
            state_q <= S_FILL;
          end
        end
        S_FILL: begin
          fill_q <= fill_now;
          idx_q  <= '0;
          if (cmd_q == CMD_INSERT) begin
            res_q.status <= (fill_now >= FW'(WAYS));
            state_q      <= S_RESP;
          end else if (fill_now == '0) begin
            state_q <= S_RESP;
          end else begin
            state_q <= S_SRCH;
          end
        end
        S_SRCH: begin
          idx_q <= idx_q + FW'(1);
          if (hit) begin
            res_q.found <= 1'b1;
            state_q     <= S_RESP;
          end else if (last) begin
            state_q <= S_RESP;
          end
        end
        S_RESP: begin
          if (!out_valid_q || out_ready_i) begin
            out_q       <= res_q;
            out_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

endmodule

@@ sv/mhs_ram.sv @@
// Generic simple dual-port RAM with registered read.
module mhs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AB   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AB-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AB-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ sv/mhs_div.sv @@
// Iterative restoring divider that yields the remainder, one bit per cycle.
module mhs_div #(
  parameter int DIVIDEND_BITS = 32,
  parameter int DIVISOR_BITS  = 7
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic [DIVIDEND_BITS-1:0] dividend_i,
  input  logic [DIVISOR_BITS-1:0]  divisor_i,
  output logic                     done_o,
  output logic [DIVISOR_BITS-1:0]  rem_o
);

  localparam int CW = $clog2(DIVIDEND_BITS + 1);

  logic                     busy_q, done_q;
  logic [CW-1:0]            cnt_q;
  logic [DIVIDEND_BITS-1:0] num_q;
  logic [DIVISOR_BITS-1:0]  den_q, rem_q;
  logic [DIVISOR_BITS:0]    trial;
  logic [DIVISOR_BITS:0]    diff;

  // shift in the next dividend bit and try a subtraction
  assign trial = {rem_q, num_q[DIVIDEND_BITS-1]};
  assign diff  = trial - {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      // one-cycle pulse after the last bit
      done_q <= !start_i && busy_q && (cnt_q == CW'(DIVIDEND_BITS - 1));
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CW'(1);
        if (cnt_q == CW'(DIVIDEND_BITS - 1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  // datapath, no reset
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= dividend_i;
      den_q <= divisor_i;
      rem_q <= '0;
    end else if (busy_q) begin
      num_q <= num_q << 1;
      if (trial >= {1'b0, den_q}) begin
        rem_q <= diff[DIVISOR_BITS-1:0];
      end else begin
        rem_q <= trial[DIVISOR_BITS-1:0];
      end
    end
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

@@ test/modulo_hash_set_unit_tb.sv @@
// Testbench of modulo_hash_set_unit: directed table and random command runs checked against a
// software hash set.
module modulo_hash_set_unit_tb;
  import mhs_pkg::*;

  localparam int NB             = NUM_BUCKETS_DEF;
  localparam int NW             = WAYS_DEF;
  localparam int IDLE_PCT       = 34;
  localparam int HOLD_CYCLES    = 400;
  localparam int STALL_LIMIT    = 3000;
  localparam int TAIL_CYCLES    = 100;
  localparam int PHASE_WORDS    = 80;
  localparam int NUM_PHASES     = 8;
  localparam int HOLD_PHASE     = 2;
  localparam int BURST_PHASE    = 4;
  localparam int RECENT_DEPTH   = 32;
  localparam cmd_e CMD_UNUSED   = cmd_e'(2'd3);

  // One row of the directed table; typed rows carry their own result
  typedef struct packed {
    cmd_e        cmd;
    logic [31:0] key;
    logic        typed;
    logic        found;
    logic        status;
  } dir_row_t;

  localparam int NUM_DIR = 24;
  localparam dir_row_t DIR_ROWS [NUM_DIR] = '{
    '{CMD_SEARCH, 32'h0000_0000, 1'b1, 1'b0, 1'b0},  // empty after reset
    '{CMD_INSERT, 32'h0000_0000, 1'b1, 1'b0, 1'b0},
    '{CMD_SEARCH, 32'h0000_0000, 1'b1, 1'b1, 1'b0},
    '{CMD_INSERT, 32'hFFFF_FFFF, 1'b1, 1'b0, 1'b0},  // top key, last bucket
    '{CMD_SEARCH, 32'hFFFF_FFFF, 1'b1, 1'b1, 1'b0},
    '{CMD_SEARCH, 32'hFFFF_FFBF, 1'b1, 1'b0, 1'b0},  // same bucket, not stored
    '{CMD_INSERT, 32'h0000_0000, 1'b0, 1'b0, 1'b0},  // duplicate takes a slot
    '{CMD_INSERT, 32'd5,         1'b1, 1'b0, 1'b0},  // fill bucket 5
    '{CMD_INSERT, 32'd69,        1'b1, 1'b0, 1'b0},
    '{CMD_INSERT, 32'd133,       1'b1, 1'b0, 1'b0},
    '{CMD_INSERT, 32'd197,       1'b1, 1'b0, 1'b0},
    '{CMD_INSERT, 32'd261,       1'b1, 1'b0, 1'b0},
    '{CMD_INSERT, 32'd325,       1'b1, 1'b0, 1'b0},
    '{CMD_INSERT, 32'd389,       1'b1, 1'b0, 1'b0},
    '{CMD_INSERT, 32'd453,       1'b1, 1'b0, 1'b0},
    '{CMD_INSERT, 32'd517,       1'b1, 1'b0, 1'b1},  // bucket full, dropped
    '{CMD_SEARCH, 32'd517,       1'b1, 1'b0, 1'b0},
    '{CMD_SEARCH, 32'd453,       1'b0, 1'b0, 1'b0},
    '{CMD_UNUSED, 32'hFFFF_FFFF, 1'b1, 1'b0, 1'b0},  // unused command
    '{CMD_CLEAR,  32'h0000_0000, 1'b1, 1'b0, 1'b0},
    '{CMD_SEARCH, 32'h0000_0000, 1'b1, 1'b0, 1'b0},  // gone after clear
    '{CMD_SEARCH, 32'hFFFF_FFFF, 1'b1, 1'b0, 1'b0},
    '{CMD_INSERT, 32'h8000_0000, 1'b0, 1'b0, 1'b0},
    '{CMD_SEARCH, 32'h8000_0000, 1'b0, 1'b0, 1'b0}
  };

  // Bucket count settings of the random phases, extremes and out-of-range values among them
  localparam logic [CFG_BITS-1:0] PHASE_CFG [NUM_PHASES] = '{
    7'd1, 7'd0, 7'd127, 7'd7, 7'd64, 7'd65, 7'd3, 7'd33
  };

  logic                clk_i;
  logic                rst_ni    = 1'b0;
  logic                in_valid  = 1'b0;
  logic                in_ready;
  in_word_t            in_word   = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  out_word_t           out_word;
  logic                cfg_we    = 1'b0;
  logic [CFG_BITS-1:0] cfg_data  = '0;

  // Software copy of the set
  logic [KEY_IN_BITS-1:0] stored_key [NB*NW];
  int unsigned            fill_level [NB];
  logic [CFG_BITS-1:0]    bucket_reg = CFG_RESET;

  out_word_t              pending_results [$];
  logic [KEY_IN_BITS-1:0] recent_keys [$];
  int                     mismatches  = 0;
  int                     stall_count = 0;
  bit                     burst_mode  = 1'b0;
  bit                     hold_req    = 1'b0;

  modulo_hash_set_unit DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_word_i   (in_word),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_word_o  (out_word),
    .cfg_we_i    (cfg_we),
    .cfg_data_i  (cfg_data)
  );

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Applies one word to the software set and returns its result
  function automatic out_word_t apply_to_set(in_word_t w);
    int unsigned divisor;
    int unsigned bucket;
    int unsigned fill;
    out_word_t   res;
    res     = '0;
    divisor = (bucket_reg == 0) ? 1 : (bucket_reg > NB) ? NB : bucket_reg;
    bucket  = w.key % divisor;
    fill    = fill_level[bucket];
    case (w.command)
      CMD_INSERT: begin
        if (fill >= NW) begin
          res.status = 1'b1;
        end else begin
          stored_key[bucket*NW + fill] = w.key;
          fill_level[bucket]           = fill + 1;
        end
      end
      CMD_SEARCH: begin
        for (int i = 0; i < fill; i++) begin
          if (stored_key[bucket*NW + i] == w.key) res.found = 1'b1;
        end
      end
      CMD_CLEAR: begin
        foreach (fill_level[i]) fill_level[i] = 0;
      end
      default: ;
    endcase
    return res;
  endfunction

  // Random word: mostly colliding keys so buckets fill and searches hit
  function automatic in_word_t random_word();
    in_word_t w;
    int       pick;
    pick = $urandom_range(0, 99);
    w.command = (pick < 47) ? CMD_INSERT : (pick < 94) ? CMD_SEARCH :
                (pick < 97) ? CMD_CLEAR : CMD_UNUSED;
    pick = $urandom_range(0, 99);
    if (pick < 35)
      w.key = $urandom_range(0, 200);
    else if (pick < 55)
      w.key = 32'hFFFF_FFFF - $urandom_range(0, 200);
    else if (pick < 85 && recent_keys.size() != 0)
      w.key = recent_keys[$urandom_range(0, recent_keys.size() - 1)];
    else
      w.key = $urandom;
    if (w.command == CMD_INSERT) begin
      recent_keys.push_back(w.key);
      if (recent_keys.size() > RECENT_DEPTH) void'(recent_keys.pop_front());
    end
    return w;
  endfunction

  // Offer one word, wait for the handshake, then log its result
  task automatic send_word(in_word_t w, bit typed, out_word_t typed_res);
    out_word_t predicted;
    in_valid <= 1'b1;
    in_word  <= w;
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
    predicted = apply_to_set(w);
    pending_results.push_back(typed ? typed_res : predicted);
  endtask

  // Random gap on the sending side, now and then a long one
  task automatic sender_gap();
    if (!burst_mode && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(0, 99) < IDLE_PCT);
      if ($urandom_range(0, 19) == 0) repeat ($urandom_range(1, 50)) @(posedge clk_i);
    end
  endtask

  // Stop sending and wait for every outstanding result
  task automatic drain();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_bucket_count(logic [CFG_BITS-1:0] value);
    cfg_we     <= 1'b1;
    cfg_data   <= value;
    bucket_reg  = value;
    @(posedge clk_i);
    cfg_we     <= 1'b0;
  endtask

  // Stimulus
  initial begin
    out_word_t typed_res;
    in_word_t  w;
    foreach (fill_level[i]) fill_level[i] = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    write_bucket_count(7'd64);

    // Directed table
    foreach (DIR_ROWS[i]) begin
      w.command        = DIR_ROWS[i].cmd;
      w.key            = DIR_ROWS[i].key;
      typed_res.found  = DIR_ROWS[i].found;
      typed_res.status = DIR_ROWS[i].status;
      sender_gap();
      send_word(w, DIR_ROWS[i].typed, typed_res);
    end
    drain();

    // Random phases, each under its own bucket count; stored keys carry over
    for (int p = 0; p < NUM_PHASES; p++) begin
      write_bucket_count(PHASE_CFG[p]);
      burst_mode = (p == BURST_PHASE);
      for (int n = 0; n < PHASE_WORDS; n++) begin
        if (p == HOLD_PHASE && n == 10) hold_req = 1'b1;
        sender_gap();
        send_word(random_word(), 1'b0, '0);
      end
      drain();
    end
    burst_mode = 1'b0;

    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Receiver: random back-pressure, one long hold-off on request
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_req = 1'b0;
      end else begin
        out_ready <= burst_mode || ($urandom_range(0, 99) >= IDLE_PCT);
      end
    end
  end

  // Result check against the oldest logged word
  always @(posedge clk_i) begin : check_results
    out_word_t want;
    if (rst_ni && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected word: found %0b status %0b", out_word.found, out_word.status);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        if (out_word.found !== want.found) begin
          $error("found: expected %0b, got %0b", want.found, out_word.found);
          mismatches++;
        end
        if (out_word.status !== want.status) begin
          $error("status: expected %0b, got %0b", want.status, out_word.status);
          mismatches++;
        end
      end
    end
  end

  // Watchdog on cycles with no word moving on either side
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_count <= 0;
    end else if (stall_count >= STALL_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      stall_count <= stall_count + 1;
    end
  end

endmodule
